@@ rtl/core/wctp_pkg.sv @@
// Shared types and constants for the weighted contiguous task partitioner.
// Used by wctp_ctrl, wctp_datapath and the core top level; no dependencies.
package wctp_pkg;

    // Sizing
    localparam int MAX_TASKS  = 64;
    localparam int MAX_NODES  = 64;
    localparam int ADDR_W     = $clog2(MAX_TASKS);
    localparam int CNT_W      = $clog2(MAX_TASKS + 1);

    // Field and datapath widths
    localparam int COST_W     = 16;
    localparam int TOTAL_W    = 22;
    localparam int MASK_W     = 64;
    localparam int NCOUNT_W   = 7;
    localparam int AVAIL_W    = 7;
    localparam int SCALED_W   = TOTAL_W + AVAIL_W;
    localparam int TIDX_W     = 6;
    localparam int NIDX_W     = 6;
    localparam int CHUNK_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NODE_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd1;

    // Reset values of the configuration registers
    localparam logic [MASK_W-1:0]   NODE_MASK_RST  = {MASK_W{1'b1}};
    localparam logic [NCOUNT_W-1:0] NODE_COUNT_RST = NCOUNT_W'(MAX_NODES);

    // Input transaction payload
    typedef struct packed {
        logic [COST_W-1:0] task_cost;
        logic              last_task;
    } in_t;

    // Output transaction payload
    typedef struct packed {
        logic [TIDX_W-1:0] task_index;
        logic [NIDX_W-1:0] node_index;
        logic              last_result;
    } out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // store incoming cost, add to total
        logic scan_clear;  // start the mask scan
        logic scan_step;   // scan one byte of the node mask
        logic walk_init;   // start the walk, read task 0
        logic decide;      // compare against the current goal
        logic seek_step;   // search one byte for the next enabled node
        logic advance;     // move to the next task, read it
        logic run_done;    // clear count and total
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_last;
        logic passed;
        logic seek_hit;
        logic seek_miss;
        logic final_task;
    } status_t;

endpackage

@@ rtl/core/wctp_datapath.sv @@
// Datapath of the partitioner: cost memory, totals, mask scan, goal compare.
// Depends on wctp_pkg; driven by wctp_ctrl through cmd_t and status_t.
module wctp_datapath
    import wctp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  in_t                   in_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output out_t                  out_data
);

    // Number of set bits in a byte
    function automatic logic [3:0] pop8(input logic [7:0] b);
        logic [3:0] s;
        s = '0;
        for (int j = 0; j < 8; j++) begin
            s = s + 4'(b[j]);
        end
        return s;
    endfunction

    // Position of the lowest set bit in a byte (0 if none)
    function automatic logic [2:0] low8(input logic [7:0] b);
        logic [2:0] p;
        p = '0;
        for (int j = 7; j >= 0; j--) begin
            if (b[j]) begin
                p = 3'(j);
            end
        end
        return p;
    endfunction

    // Configuration and run control state
    logic [MASK_W-1:0]   node_mask_reg,    node_mask_next;
    logic [NCOUNT_W-1:0] node_count_reg,   node_count_next;
    logic [CNT_W-1:0]    tasks_loaded_reg, tasks_loaded_next;
    logic [TOTAL_W-1:0]  cost_total_reg,   cost_total_next;

    // Walk state
    logic [CHUNK_W-1:0]  scan_chunk_reg, scan_chunk_next;
    logic [CHUNK_W-1:0]  seek_chunk_reg, seek_chunk_next;
    logic                found_reg,      found_next;
    logic [AVAIL_W-1:0]  avail_reg,      avail_next;
    logic [NIDX_W-1:0]   cur_reg,        cur_next;
    logic [SCALED_W-1:0] goal_reg,       goal_next;
    logic [SCALED_W-1:0] run_reg,        run_next;
    logic [ADDR_W-1:0]   t_reg,          t_next;

    // Cost memory
    logic [COST_W-1:0]   cost_mem [MAX_TASKS];
    logic [COST_W-1:0]   rd_cost_reg;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                store_full;

    logic [NCOUNT_W-1:0] n_used;
    logic [MASK_W-1:0]   used_mask;
    logic [7:0]          scan_byte;
    logic [7:0]          seek_byte;
    logic [7:0]          seek_keep;
    logic [AVAIL_W-1:0]  avail_sum;
    logic [SCALED_W-1:0] cost_prod;
    logic [SCALED_W-1:0] next_scaled;

    // Clamp the node count and mask off unused nodes
    always_comb
    begin
        if (node_count_reg == '0) begin
            n_used = NCOUNT_W'(1);
        end else if (node_count_reg > NCOUNT_W'(MAX_NODES)) begin
            n_used = NCOUNT_W'(MAX_NODES);
        end else begin
            n_used = node_count_reg;
        end
        for (int i = 0; i < MASK_W; i++) begin
            used_mask[i] = node_mask_reg[i] && (NCOUNT_W'(i) < n_used);
        end
    end

    // Mask bytes for the scan and the seek; seek skips nodes at or below cur
    assign scan_byte = used_mask[{scan_chunk_reg, 3'b000} +: 8];
    assign seek_byte = used_mask[{seek_chunk_reg, 3'b000} +: 8];
    always_comb
    begin
        for (int j = 0; j < 8; j++) begin
            seek_keep[j] = seek_byte[j] &&
                ((seek_chunk_reg != cur_reg[NIDX_W-1:3]) || (3'(j) > cur_reg[2:0]));
        end
    end

    assign avail_sum   = avail_reg + AVAIL_W'(pop8(scan_byte));
    assign cost_prod   = SCALED_W'(rd_cost_reg) * SCALED_W'(avail_reg);
    assign next_scaled = run_reg + cost_prod;
    assign store_full  = (tasks_loaded_reg == CNT_W'(MAX_TASKS));

    // Status back to the controller
    assign status.scan_last  = (scan_chunk_reg == '1);
    assign status.passed     = (next_scaled > goal_reg);
    assign status.seek_hit   = (seek_keep != '0);
    assign status.seek_miss  = (seek_keep == '0) && (seek_chunk_reg == '1);
    assign status.final_task = (CNT_W'(t_reg) + CNT_W'(1) == tasks_loaded_reg);

    // Next state of configuration and run control
    always_comb
    begin
        node_mask_next    = node_mask_reg;
        node_count_next   = node_count_reg;
        tasks_loaded_next = tasks_loaded_reg;
        cost_total_next   = cost_total_reg;
        if (cfg_we && cfg_index == REG_NODE_MASK) begin
            node_mask_next = cfg_data[MASK_W-1:0];
        end
        if (cfg_we && cfg_index == REG_NODE_COUNT) begin
            node_count_next = cfg_data[NCOUNT_W-1:0];
        end
        if (cmd.load && !store_full) begin
            tasks_loaded_next = tasks_loaded_reg + CNT_W'(1);
            cost_total_next   = cost_total_reg + TOTAL_W'(in_data.task_cost);
        end
        if (cmd.run_done) begin
            tasks_loaded_next = '0;
            cost_total_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            node_mask_reg    <= NODE_MASK_RST;
            node_count_reg   <= NODE_COUNT_RST;
            tasks_loaded_reg <= '0;
            cost_total_reg   <= '0;
        end else begin
            node_mask_reg    <= node_mask_next;
            node_count_reg   <= node_count_next;
            tasks_loaded_reg <= tasks_loaded_next;
            cost_total_reg   <= cost_total_next;
        end
    end

    // Next state of the walk
    always_comb
    begin
        scan_chunk_next = scan_chunk_reg;
        seek_chunk_next = seek_chunk_reg;
        found_next      = found_reg;
        avail_next      = avail_reg;
        cur_next        = cur_reg;
        goal_next       = goal_reg;
        run_next        = run_reg;
        t_next          = t_reg;
        if (cmd.scan_clear) begin
            scan_chunk_next = '0;
            found_next      = 1'b0;
            avail_next      = '0;
            cur_next        = '0;
        end
        if (cmd.scan_step) begin
            scan_chunk_next = scan_chunk_reg + CHUNK_W'(1);
            // an empty mask still counts as one node
            if (status.scan_last && avail_sum == '0) begin
                avail_next = AVAIL_W'(1);
            end else begin
                avail_next = avail_sum;
            end
            if (!found_reg && scan_byte != '0) begin
                found_next = 1'b1;
                cur_next   = {scan_chunk_reg, low8(scan_byte)};
            end
        end
        if (cmd.walk_init) begin
            t_next    = '0;
            run_next  = '0;
            goal_next = SCALED_W'(cost_total_reg);
        end
        if (cmd.decide) begin
            run_next        = next_scaled;
            seek_chunk_next = cur_reg[NIDX_W-1:3];
        end
        if (cmd.seek_step) begin
            if (status.seek_hit) begin
                cur_next  = {seek_chunk_reg, low8(seek_keep)};
                goal_next = goal_reg + SCALED_W'(cost_total_reg);
            end else begin
                seek_chunk_next = seek_chunk_reg + CHUNK_W'(1);
            end
        end
        if (cmd.advance) begin
            t_next = t_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        scan_chunk_reg <= scan_chunk_next;
        seek_chunk_reg <= seek_chunk_next;
        found_reg      <= found_next;
        avail_reg      <= avail_next;
        cur_reg        <= cur_next;
        goal_reg       <= goal_next;
        run_reg        <= run_next;
        t_reg          <= t_next;
    end

    // Cost memory: write while loading, registered read during the walk
    assign rd_en   = cmd.walk_init || cmd.advance;
    assign rd_addr = cmd.walk_init ? '0 : t_reg + ADDR_W'(1);

    always_ff @(posedge clk)
    begin
        if (cmd.load && !store_full) begin
            cost_mem[tasks_loaded_reg[ADDR_W-1:0]] <= in_data.task_cost;
        end
        if (rd_en) begin
            rd_cost_reg <= cost_mem[rd_addr];
        end
    end

    // Result payload
    assign out_data.task_index  = TIDX_W'(t_reg);
    assign out_data.node_index  = cur_reg;
    assign out_data.last_result = status.final_task;

    // Load count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tasks_loaded_reg <= CNT_W'(MAX_TASKS))
        else $error("task count beyond store depth");

    // Goal compare always sees at least one node
    a_avail_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |-> avail_reg != '0)
        else $error("enabled node count is zero during walk");

    // A node change always moves upward and raises the goal unless the cost total is zero
    a_seek_up: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.seek_step && status.seek_hit |=>
            (cur_reg > $past(cur_reg)) && (goal_reg != $past(goal_reg) ||
            $past(cost_total_reg) == '0))
        else $error("node change did not move upward");

    // Walk never runs past the loaded tasks
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |-> CNT_W'(t_reg) + CNT_W'(1) < tasks_loaded_reg)
        else $error("walk ran past last loaded task");

endmodule

@@ rtl/core/wctp_ctrl.sv @@
// Controller of the partitioner: load, mask scan, and per-task walk sequencing.
// Depends on wctp_pkg; steers wctp_datapath through cmd_t and status_t.
module wctp_ctrl
    import wctp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_last,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_LOAD   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_FETCH  = 6'b000100,
        ST_DECIDE = 6'b001000,
        ST_SEEK   = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load = 1'b1;
                    if (in_last) begin
                        cmd.scan_clear = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.walk_init = 1'b1;
                state_next    = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = status.passed ? ST_SEEK : ST_EMIT;
            end
            ST_SEEK:
            begin
                cmd.seek_step = 1'b1;
                if (status.seek_hit || status.seek_miss) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready) begin
                    if (status.final_task) begin
                        cmd.run_done = 1'b1;
                        state_next   = ST_LOAD;
                    end else begin
                        cmd.advance = 1'b1;
                        state_next  = ST_DECIDE;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/weighted_contiguous_task_partitioner_core.sv @@
// Weighted contiguous task partitioner, top level. Loads task costs and then
// assigns each task in load order to an enabled node. Depends on wctp_pkg,
// wctp_ctrl and wctp_datapath.
//
// Costs are taken one per cycle while loading. The transaction with last_task
// set ends the run: a scan of the node mask (one byte per cycle) and a read of
// the first cost follow, then each task takes a goal compare, then, when the
// goal is passed, a search for the next enabled node one mask byte per cycle,
// then the result, which is held until out_ready. Inputs are not accepted
// while a run is being emitted. Up to 64 costs are held; further costs in a
// run are dropped.
module weighted_contiguous_task_partitioner_core
    import wctp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_t                  out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    // Sequencing
    wctp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_data.last_task),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Storage and arithmetic
    wctp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule
